[hdl/soat_pkg.sv]
// Shared types and constants of the one-at-a-time string hash block.
package soat_pkg;

    localparam int BYTE_WIDTH = 8;
    localparam int CAP_WIDTH  = 31;

    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 31'd17;

    localparam int SHIFT_MIX_ADD = 10;
    localparam int SHIFT_MIX_XOR = 6;
    localparam int SHIFT_FIN_ADD_A = 3;
    localparam int SHIFT_FIN_XOR = 11;
    localparam int SHIFT_FIN_ADD_B = 15;

    typedef logic [2:0] alu_op_t;

    localparam alu_op_t OP_ADD_BYTE  = 3'd0;
    localparam alu_op_t OP_ADD_SHL10 = 3'd1;
    localparam alu_op_t OP_XOR_SHR6  = 3'd2;
    localparam alu_op_t OP_ADD_SHL3  = 3'd3;
    localparam alu_op_t OP_XOR_SHR11 = 3'd4;
    localparam alu_op_t OP_ADD_SHL15 = 3'd5;

    typedef logic [BYTE_WIDTH-1:0] char_t;
    typedef logic [CAP_WIDTH-1:0]  cap_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

[hdl/soat_if.sv]
// Valid/ready channels for string characters and bucket indexes.
interface soat_char_if;
    logic                valid;
    logic                ready;
    soat_pkg::char_t     char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface soat_bucket_if;
    logic                valid;
    logic                ready;
    soat_pkg::cap_t      bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

[hdl/soat_alu.sv]
// Shared shift-add-xor unit for the mixing and finalization steps.
module soat_alu #(
    parameter int HASH_WIDTH = 64
) (
    input  logic [HASH_WIDTH-1:0] acc,
    input  soat_pkg::char_t       char_byte,
    input  soat_pkg::alu_op_t     op,
    output logic [HASH_WIDTH-1:0] result
);

    logic [HASH_WIDTH-1:0] operand;
    logic                  use_xor;

    always_comb
    begin
        operand = '0;
        use_xor = 1'b0;
        case (op)
            soat_pkg::OP_ADD_BYTE:
            begin
                operand = {{(HASH_WIDTH-soat_pkg::BYTE_WIDTH){char_byte[soat_pkg::BYTE_WIDTH-1]}},
                           char_byte};
            end
            soat_pkg::OP_ADD_SHL10:
            begin
                operand = acc << soat_pkg::SHIFT_MIX_ADD;
            end
            soat_pkg::OP_XOR_SHR6:
            begin
                operand = acc >> soat_pkg::SHIFT_MIX_XOR;
                use_xor = 1'b1;
            end
            soat_pkg::OP_ADD_SHL3:
            begin
                operand = acc << soat_pkg::SHIFT_FIN_ADD_A;
            end
            soat_pkg::OP_XOR_SHR11:
            begin
                operand = acc >> soat_pkg::SHIFT_FIN_XOR;
                use_xor = 1'b1;
            end
            soat_pkg::OP_ADD_SHL15:
            begin
                operand = acc << soat_pkg::SHIFT_FIN_ADD_B;
            end
            default:
            begin
                operand = '0;
                use_xor = 1'b0;
            end
        endcase
    end

    assign result = use_xor ? (acc ^ operand) : (acc + operand);

endmodule

[hdl/soat_mod.sv]
// Bit-serial restoring remainder of the final hash by the capacity.
module soat_mod #(
    parameter int HASH_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [HASH_WIDTH-1:0] dividend,
    input  soat_pkg::cap_t        divisor,
    output soat_pkg::mod_stat_t   stat,
    output soat_pkg::cap_t        remainder
);

    localparam int CNT_W = $clog2(HASH_WIDTH);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [HASH_WIDTH-1:0] quot_reg, quot_next;
    soat_pkg::cap_t        rem_reg, rem_next;
    logic [soat_pkg::CAP_WIDTH:0] trial;
    logic [soat_pkg::CAP_WIDTH:0] divisor_ext;
    logic                  fits;

    assign trial       = {rem_reg, quot_reg[HASH_WIDTH-1]};
    assign divisor_ext = {1'b0, divisor};
    assign fits        = trial >= divisor_ext;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(HASH_WIDTH - 1);
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = quot_reg << 1;
            rem_next  = fits ? soat_pkg::CAP_WIDTH'(trial - divisor_ext)
                             : trial[soat_pkg::CAP_WIDTH-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign remainder = rem_next;

endmodule

[hdl/string_hash_one_at_a_time.sv]
// Top level of the one-at-a-time string hash block.
// One character arrives per beat on char_in. A nonzero character takes the beat
// plus three passes through the shared shift-add-xor unit. A zero character
// ends the string: three finalization passes through the same unit, then a
// bit-serial remainder against the capacity register, then a load of the result
// register. char_in is not ready while a character is in work. The result
// register frees the input side, so new characters are taken while a bucket
// index waits on bucket_out; a terminator that finishes before that index is
// taken holds until it is. Capacity zero gives bucket index 0. cfg_we writes
// the capacity; the user must raise it only while idle, as the block does
// not enforce this itself.
module string_hash_one_at_a_time #(
    parameter int HASH_WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  soat_pkg::cap_t       cfg_wdata,
    soat_char_if.sink            char_in,
    soat_bucket_if.source        bucket_out
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MIX_ADD  = 4'd1;
    localparam logic [3:0] ST_MIX_SHL  = 4'd2;
    localparam logic [3:0] ST_MIX_XOR  = 4'd3;
    localparam logic [3:0] ST_FIN_A    = 4'd4;
    localparam logic [3:0] ST_FIN_B    = 4'd5;
    localparam logic [3:0] ST_FIN_C    = 4'd6;
    localparam logic [3:0] ST_MOD_WAIT = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [HASH_WIDTH-1:0] acc_reg, acc_next;
    soat_pkg::char_t       byte_reg, byte_next;
    soat_pkg::cap_t        cap_reg;
    soat_pkg::cap_t        bucket_reg, bucket_next;
    logic                  out_valid_reg, out_valid_next;

    soat_pkg::alu_op_t     alu_op;
    logic [HASH_WIDTH-1:0] alu_result;
    logic                  mod_start;
    soat_pkg::mod_stat_t   mod_stat;
    soat_pkg::cap_t        mod_rem;
    logic                  in_beat;
    logic                  out_free;

    soat_alu #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_alu (
        .acc       (acc_reg),
        .char_byte (byte_reg),
        .op        (alu_op),
        .result    (alu_result)
    );

    soat_mod #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (alu_result),
        .divisor   (cap_reg),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    assign char_in.ready = (state_reg == ST_IDLE);
    assign in_beat       = char_in.valid && char_in.ready;
    assign out_free      = !out_valid_reg || bucket_out.ready;

    always_comb
    begin
        case (state_reg)
            ST_MIX_ADD: alu_op = soat_pkg::OP_ADD_BYTE;
            ST_MIX_SHL: alu_op = soat_pkg::OP_ADD_SHL10;
            ST_MIX_XOR: alu_op = soat_pkg::OP_XOR_SHR6;
            ST_FIN_A:   alu_op = soat_pkg::OP_ADD_SHL3;
            ST_FIN_B:   alu_op = soat_pkg::OP_XOR_SHR11;
            ST_FIN_C:   alu_op = soat_pkg::OP_ADD_SHL15;
            default:    alu_op = soat_pkg::OP_ADD_BYTE;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        byte_next      = byte_reg;
        bucket_next    = bucket_reg;
        out_valid_next = out_valid_reg;
        mod_start      = 1'b0;

        if (out_valid_reg && bucket_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    byte_next  = char_in.char_byte;
                    state_next = (char_in.char_byte == '0) ? ST_FIN_A : ST_MIX_ADD;
                end
            end
            ST_MIX_ADD:
            begin
                acc_next   = alu_result;
                state_next = ST_MIX_SHL;
            end
            ST_MIX_SHL:
            begin
                acc_next   = alu_result;
                state_next = ST_MIX_XOR;
            end
            ST_MIX_XOR:
            begin
                acc_next   = alu_result;
                state_next = ST_IDLE;
            end
            ST_FIN_A:
            begin
                acc_next   = alu_result;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                acc_next   = alu_result;
                state_next = ST_FIN_C;
            end
            ST_FIN_C:
            begin
                mod_start  = 1'b1;
                acc_next   = '0;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free && !mod_stat.busy)
                begin
                    bucket_next    = (cap_reg == '0) ? '0 : mod_rem;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cap_reg       <= soat_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bucket_reg <= bucket_next;
    end

    assign bucket_out.valid        = out_valid_reg;
    assign bucket_out.bucket_index = bucket_reg;

endmodule

[hdl/soat_check.sv]
// Port-level checker for the one-at-a-time string hash block, with its bind.
module soat_check (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input soat_pkg::cap_t     cfg_wdata,
    input logic               in_valid,
    input logic               in_ready,
    input soat_pkg::char_t    in_char,
    input logic               out_valid,
    input logic               out_ready,
    input soat_pkg::cap_t     out_bucket
);

    soat_pkg::cap_t cap_shadow_reg;
    logic           in_beat;

    assign in_beat = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_shadow_reg <= soat_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            cap_shadow_reg <= cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bucket))
        else $error("bucket beat dropped or changed while stalled");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_bucket < cap_shadow_reg)
                      || (cap_shadow_reg == '0 && out_bucket == '0))
        else $error("bucket index not below capacity");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("ready while a character is in work");

    a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && in_char != '0 |=> !$rose(out_valid))
        else $error("result raised by a nonzero character");

    a_char_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && in_char != '0 |-> ##4 in_ready)
        else $error("nonzero character did not finish in four cycles");

endmodule

bind string_hash_one_at_a_time soat_check u_soat_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (char_in.valid),
    .in_ready   (char_in.ready),
    .in_char    (char_in.char_byte),
    .out_valid  (bucket_out.valid),
    .out_ready  (bucket_out.ready),
    .out_bucket (bucket_out.bucket_index)
);
